/* rtl/teoq_pkg.sv */
`timescale 1ns / 1ps
// Shared types and codes for the timestamp-ordered event queue.
// No dependencies; imported by every module of the block.
package teoq_pkg;

    localparam int KIND_BITS   = 1;
    localparam int NODE_BITS   = 3;
    localparam int OUTNODE_BITS = 2;
    localparam int SERVER_BITS = 4;
    localparam int NODE_COUNT  = 4;

    typedef enum logic [0:0] {
        OP_INSERT  = 1'b0,
        OP_EXTRACT = 1'b1
    } op_t;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_OUTSIDE = 2'd1,
        ST_FULL    = 2'd2,
        ST_EMPTY   = 2'd3
    } status_t;

    // Event attributes carried with each stamp
    typedef struct packed {
        logic [KIND_BITS-1:0]    kind;
        logic [OUTNODE_BITS-1:0] node;
        logic [SERVER_BITS-1:0]  server;
    } meta_t;

    // Per-cycle command broadcast to every cell
    typedef struct packed {
        logic ins;
        logic ext;
    } cmd_t;

endpackage

/* rtl/teoq_cell.sv */
`timescale 1ns / 1ps
// One slot of the sorted event chain: holds one event, shifts right on insert, left on extract.
// Depends on teoq_pkg.
module teoq_cell #(
    parameter int STAMP_BITS = 48
) (
    input  logic                  clk,
    input  teoq_pkg::cmd_t        cmd,
    input  logic                  occupied,
    input  teoq_pkg::meta_t       new_meta,
    input  logic [STAMP_BITS-1:0] new_stamp,
    input  logic                  left_ge,
    input  teoq_pkg::meta_t       left_meta,
    input  logic [STAMP_BITS-1:0] left_stamp,
    input  teoq_pkg::meta_t       right_meta,
    input  logic [STAMP_BITS-1:0] right_stamp,
    output logic                  ge,
    output teoq_pkg::meta_t       meta,
    output logic [STAMP_BITS-1:0] stamp
);
    import teoq_pkg::*;

    meta_t                 meta_reg, meta_next;
    logic [STAMP_BITS-1:0] stamp_reg, stamp_next;

    // Empty slots count as later than any new event
    assign ge    = !occupied || (stamp_reg >= new_stamp);
    assign meta  = meta_reg;
    assign stamp = stamp_reg;

    always_comb
    begin
        meta_next  = meta_reg;
        stamp_next = stamp_reg;
        priority if (cmd.ins && ge && left_ge)
        begin
            meta_next  = left_meta;
            stamp_next = left_stamp;
        end
        else if (cmd.ins && ge)
        begin
            meta_next  = new_meta;
            stamp_next = new_stamp;
        end
        else if (cmd.ext)
        begin
            meta_next  = right_meta;
            stamp_next = right_stamp;
        end
        else
        begin
            meta_next  = meta_reg;
            stamp_next = stamp_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        meta_reg  <= meta_next;
        stamp_reg <= stamp_next;
    end

endmodule

/* rtl/timestamp_ordered_event_queue.sv */
`timescale 1ns / 1ps
// Timestamp-ordered event queue: top level, a chain of teoq_cell slots plus result register.
// Depends on teoq_pkg and teoq_cell.
//
// Usage: the input channel (in_valid / in_stall) carries one operation per transfer:
// insert an event or extract the earliest one. Every transfer yields exactly one result
// on the output channel (out_valid / out_stall) with a status code; extract results also
// carry the removed event. Events with equal stamps leave newest first.
// Result: registered, and presented in the cycle after the input transfer.
// Throughput: one operation per cycle while in_stall is low. Every slot compares its stamp with the incoming
// one in parallel and shifts by one place.
// Stall: in_stall is raised while a result is held and out_stall is high, so at most one
// result waits; the queue contents do not move during a stall.
// Reset: clears the fill count and the result valid flag; the queue reads as empty and
// slot contents and result fields are left as they are.
module timestamp_ordered_event_queue #(
    parameter int QUEUE_DEPTH = 32,
    parameter int STAMP_BITS  = 48
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic                               operation,
    input  logic [teoq_pkg::KIND_BITS-1:0]     event_kind,
    input  logic [teoq_pkg::NODE_BITS-1:0]     dest_node,
    input  logic [teoq_pkg::SERVER_BITS-1:0]   source_server,
    input  logic [STAMP_BITS-1:0]              event_stamp,
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic [1:0]                         status_code,
    output logic [teoq_pkg::KIND_BITS-1:0]     out_kind,
    output logic [teoq_pkg::OUTNODE_BITS-1:0]  out_node,
    output logic [teoq_pkg::SERVER_BITS-1:0]   out_server,
    output logic [STAMP_BITS-1:0]              out_stamp
);
    import teoq_pkg::*;

    localparam int CNT_BITS = $clog2(QUEUE_DEPTH + 1);

    logic [CNT_BITS-1:0]   count_reg, count_next;
    logic                  out_valid_reg;
    status_t               status_reg, status_next;
    meta_t                 res_meta_reg, res_meta_next;
    logic [STAMP_BITS-1:0] res_stamp_reg, res_stamp_next;

    logic    xfer;
    logic    outside, full, empty;
    cmd_t    cmd;
    meta_t   new_meta;

    meta_t                 cell_meta  [QUEUE_DEPTH];
    logic [STAMP_BITS-1:0] cell_stamp [QUEUE_DEPTH];
    logic                  cell_ge    [QUEUE_DEPTH];

    assign in_stall = out_valid_reg && out_stall;
    assign xfer     = in_valid && !in_stall;

    assign outside = {1'b0, dest_node} >= (NODE_BITS + 1)'(NODE_COUNT);
    assign full    = count_reg == CNT_BITS'(QUEUE_DEPTH);
    assign empty   = count_reg == '0;

    assign cmd.ins = xfer && (operation == OP_INSERT) && !outside && !full;
    assign cmd.ext = xfer && (operation == OP_EXTRACT) && !empty;

    assign new_meta.kind   = event_kind;
    assign new_meta.node   = dest_node[OUTNODE_BITS-1:0];
    assign new_meta.server = source_server;

    genvar i;
    generate
        for (i = 0; i < QUEUE_DEPTH; i++)
        begin : g_cell
            logic                  l_ge;
            meta_t                 l_meta, r_meta;
            logic [STAMP_BITS-1:0] l_stamp, r_stamp;

            if (i == 0)
            begin : g_first
                assign l_ge    = 1'b0;
                assign l_meta  = new_meta;
                assign l_stamp = event_stamp;
            end
            else
            begin : g_mid
                assign l_ge    = cell_ge[i-1];
                assign l_meta  = cell_meta[i-1];
                assign l_stamp = cell_stamp[i-1];
            end

            if (i == QUEUE_DEPTH - 1)
            begin : g_last
                assign r_meta  = cell_meta[i];
                assign r_stamp = cell_stamp[i];
            end
            else
            begin : g_inner
                assign r_meta  = cell_meta[i+1];
                assign r_stamp = cell_stamp[i+1];
            end

            teoq_cell #(
                .STAMP_BITS (STAMP_BITS)
            ) u_cell (
                .clk         (clk),
                .cmd         (cmd),
                .occupied    (count_reg > CNT_BITS'(i)),
                .new_meta    (new_meta),
                .new_stamp   (event_stamp),
                .left_ge     (l_ge),
                .left_meta   (l_meta),
                .left_stamp  (l_stamp),
                .right_meta  (r_meta),
                .right_stamp (r_stamp),
                .ge          (cell_ge[i]),
                .meta        (cell_meta[i]),
                .stamp       (cell_stamp[i])
            );
        end
    endgenerate

    always_comb
    begin
        count_next     = count_reg;
        status_next    = status_reg;
        res_meta_next  = res_meta_reg;
        res_stamp_next = res_stamp_reg;
        if (xfer)
        begin
            res_meta_next  = '0;
            res_stamp_next = '0;
            priority if (operation == OP_INSERT && outside)
                status_next = ST_OUTSIDE;
            else if (operation == OP_INSERT && full)
                status_next = ST_FULL;
            else if (operation == OP_INSERT)
            begin
                status_next = ST_OK;
                count_next  = count_reg + 1'b1;
            end
            else if (empty)
                status_next = ST_EMPTY;
            else
            begin
                status_next    = ST_OK;
                count_next     = count_reg - 1'b1;
                res_meta_next  = cell_meta[0];
                res_stamp_next = cell_stamp[0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            if (xfer)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        status_reg    <= status_next;
        res_meta_reg  <= res_meta_next;
        res_stamp_reg <= res_stamp_next;
    end

    assign out_valid   = out_valid_reg;
    assign status_code = status_reg;
    assign out_kind    = res_meta_reg.kind;
    assign out_node    = res_meta_reg.node;
    assign out_server  = res_meta_reg.server;
    assign out_stamp   = res_stamp_reg;

endmodule

/* rtl/teoq_checker.sv */
`timescale 1ns / 1ps
// Port-level checks for the timestamp-ordered event queue, bound to the top level.
// Depends on teoq_pkg and timestamp_ordered_event_queue.
module teoq_checker #(
    parameter int STAMP_BITS = 48
) (
    input logic                              clk,
    input logic                              rst_n,
    input logic                              in_valid,
    input logic                              in_stall,
    input logic                              operation,
    input logic                              out_valid,
    input logic                              out_stall,
    input logic [1:0]                        status_code,
    input logic [teoq_pkg::KIND_BITS-1:0]    out_kind,
    input logic [teoq_pkg::OUTNODE_BITS-1:0] out_node,
    input logic [teoq_pkg::SERVER_BITS-1:0]  out_server,
    input logic [STAMP_BITS-1:0]             out_stamp
);
    import teoq_pkg::*;

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("result dropped while stalled");

    a_stall: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall == (out_valid && out_stall))
        else $error("input stall does not follow held result");

    a_result: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> out_valid)
        else $error("transfer produced no result");

    a_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status_code != ST_OK |->
            out_kind == '0 && out_node == '0 && out_server == '0 && out_stamp == '0)
        else $error("non-ok result carries event data");

    a_insert: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && operation == OP_INSERT |=>
            status_code != ST_EMPTY && out_stamp == '0)
        else $error("insert answered as extract");

endmodule

bind timestamp_ordered_event_queue teoq_checker #(
    .STAMP_BITS (STAMP_BITS)
) u_teoq_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .operation   (operation),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .status_code (status_code),
    .out_kind    (out_kind),
    .out_node    (out_node),
    .out_server  (out_server),
    .out_stamp   (out_stamp)
);
